// File: sv/buddy_block_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the buddy block allocator core
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTH
// Clocked assertion, masked during reset.
`define BBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Clocked assertion, checked during reset as well.
`define BBA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error("assertion failed");
`else
`define BBA_ASSERT(lbl, prop)
`define BBA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared constants and types of the allocator core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int TOP_ORDER_DEF = 10;  // region holds 2^TOP_ORDER minimum blocks
  localparam int OW            = 4;   // order field width
  localparam int CW            = 5;   // config register width
  localparam int WL            = 5;   // log2 of bitmap word width
  localparam int W             = 1 << WL;
  localparam logic [CW-1:0] LG_RESET = CW'(4);
  localparam logic [CW-1:0] LG_CAP   = CW'(16);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOMEM   = 2'd1,
    STAT_BADSIZE = 2'd2,
    STAT_BADFREE = 2'd3
  } status_e;

endpackage

`default_nettype wire

// File: sv/buddy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// Buddy block allocator core
// Allocates and frees power-of-two blocks of a region of 2^TOP_ORDER minimum
// blocks. Each request is one input beat and gives one result beat. The free
// bitmap of all (order, block) nodes lives in a RAM of 32-bit words; the
// start flag and order of every allocated block live in a second RAM indexed
// by minimum block. After reset a clearing pass sweeps both RAMs before the
// first beat is taken. An allocate scans the bitmap one word at a time,
// starting at the target order and climbing, then splits one level at a
// time; a free checks one buddy at a time and ends with the final set (the
// buddy check is skipped when the merge climbs to the whole region). A
// rejected request goes straight to the result. The single RAM port pair
// sets the pace: every bitmap update is a read, then a write of the
// modified word, never overlapped. A finished result waits in the output
// register; a new beat is accepted once the core is back in idle, and the
// next result holds the core in its done state until the previous one is
// taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "buddy_block_allocator_core_assert.svh"

module buddy_block_allocator_core #(
  parameter int TOP_ORDER = bba_pkg::TOP_ORDER_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config: min_block_log2
  input  wire logic                  cfg_we_i,
  input  wire logic [bba_pkg::CW-1:0] cfg_wdata_i,
  // request stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [63:0]           s_axis_tdata,   // [31:0] request_size, [63:32] free_offset
  input  wire logic                  s_axis_tuser,   // [0] opcode
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [39:0]                m_axis_tdata,   // [31:0] block_offset, [35:32] block_order
  output logic [1:0]                 m_axis_tuser    // [1:0] status
);
  import bba_pkg::*;

  localparam int UNITS  = 1 << TOP_ORDER;
  localparam int NODES  = (2 << TOP_ORDER) - 1;
  localparam int NWORDS = (NODES + W - 1) / W;
  localparam int BAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int NX     = BAW + WL;          // node index width
  localparam int UW     = TOP_ORDER + 1;     // unit count width
  localparam int AMW    = OW + 1;            // start flag + order

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_A_CHK, ST_A_TGT, ST_S_RD, ST_S_CHK, ST_SPLIT,
    ST_SPL_WR, ST_F_CHK, ST_F_RD, ST_M_RD, ST_M_CHK, ST_SET_RD, ST_SET_WR,
    ST_DONE
  } state_e;

  // Node of block k at order o in the flat bitmap.
  function automatic logic [NX-1:0] node_of(input logic [OW-1:0] o,
                                            input logic [NX-1:0] k);
    logic [NX-1:0] base;
    base = (NX'(1) << (NX'(TOP_ORDER) - NX'(o))) - NX'(1);
    return base + k;
  endfunction

  function automatic logic [NX-1:0] last_of(input logic [OW-1:0] o);
    return (NX'(1) << (NX'(TOP_ORDER) - NX'(o) + NX'(1))) - NX'(2);
  endfunction

  state_e               state_q;
  logic [CW-1:0]        cfg_q;
  logic [31:0]          size_q, offs_q;
  logic [UW-1:0]        units_q;
  logic [OW-1:0]        tgt_q, o_q, i_q;
  logic [BAW-1:0]       w_q;
  logic [TOP_ORDER-1:0] s_q;
  logic [NX-1:0]        node_q;
  logic [UW-1:0]        clr_q;
  status_e              st_q;
  logic [31:0]          roff_q;
  logic [OW-1:0]        rord_q;
  logic                 mval_q;
  status_e              mst_q;
  logic [31:0]          moff_q;
  logic [OW-1:0]        mord_q;

  // RAM ports
  logic                 bm_we, bm_re, am_we, am_re;
  logic [BAW-1:0]       bm_waddr, bm_raddr;
  logic [W-1:0]         bm_wdata, bm_rdata;
  logic [TOP_ORDER-1:0] am_waddr, am_raddr;
  logic [AMW-1:0]       am_wdata, am_rdata;

  bba_ram #(.WIDTH(W), .DEPTH(NWORDS)) u_bitmap (
    .clk_i(clk_i), .we_i(bm_we), .waddr_i(bm_waddr), .wdata_i(bm_wdata),
    .re_i(bm_re), .raddr_i(bm_raddr), .rdata_o(bm_rdata)
  );

  bba_ram #(.WIDTH(AMW), .DEPTH(UNITS)) u_alloc (
    .clk_i(clk_i), .we_i(am_we), .waddr_i(am_waddr), .wdata_i(am_wdata),
    .re_i(am_re), .raddr_i(am_raddr), .rdata_o(am_rdata)
  );

  // Effective block size log2, capped.
  logic [CW-1:0] lg;
  assign lg = (cfg_q > LG_CAP) ? LG_CAP : cfg_q;

  // Allocate size checks.
  logic [32:0] tot, rnd, ufull;
  logic        bad_size;
  assign tot      = 33'(UNITS) << lg;
  assign rnd      = 33'(size_q) + ((33'(1) << lg) - 33'(1));
  assign ufull    = rnd >> lg;
  assign bad_size = (size_q == '0) || (33'(size_q) > tot);

  // Target order: bit length of units - 1.
  logic [UW-1:0] um1;
  logic [OW-1:0] tgt_c;
  always_comb begin
    um1   = units_q - UW'(1);
    tgt_c = '0;
    for (int j = 0; j < UW; j++) begin
      if (um1[j]) tgt_c = OW'(j + 1);
    end
  end

  // Scan: mask the word to the nodes of order o_q and find lowest free.
  logic [NX-1:0] lo_c, hi_c, nj;
  logic [W-1:0]  hit;
  logic [WL-1:0] pe;
  logic          any_hit;
  always_comb begin
    lo_c = node_of(o_q, '0);
    hi_c = last_of(o_q);
    hit  = '0;
    for (int j = 0; j < W; j++) begin
      nj     = {w_q, WL'(j)};
      hit[j] = bm_rdata[j] && (nj >= lo_c) && (nj <= hi_c);
    end
    pe = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (hit[j]) pe = WL'(j);
    end
    any_hit = |hit;
  end

  logic [NX-1:0]        fnode, kidx, kshift;
  logic [TOP_ORDER-1:0] s_found;
  assign fnode   = {w_q, pe};
  assign kidx    = fnode - lo_c;
  assign kshift  = kidx << o_q;
  assign s_found = kshift[TOP_ORDER-1:0];

  // Node addresses for split, merge and final set.
  logic [OW-1:0]        im1;
  logic [NX-1:0]        split_node, buddy_node, set_node;
  logic [TOP_ORDER-1:0] buddy;
  assign im1        = i_q - OW'(1);
  assign split_node = node_of(im1, NX'(s_q >> im1) + NX'(1));
  assign buddy      = s_q ^ (TOP_ORDER'(1) << o_q);
  assign buddy_node = node_of(o_q, NX'(buddy >> o_q));
  assign set_node   = node_of(o_q, NX'(s_q >> o_q));

  // Free offset checks.
  logic [31:0] fsh;
  logic        bad_free;
  assign fsh      = offs_q >> lg;
  assign bad_free = ((offs_q & ((32'(1) << lg) - 32'(1))) != '0) ||
                    ((fsh >> TOP_ORDER) != '0);

  logic [OW-1:0] am_ord;
  assign am_ord = (am_rdata[OW-1:0] > OW'(TOP_ORDER)) ? OW'(TOP_ORDER) : am_rdata[OW-1:0];

  // RAM port steering.
  always_comb begin
    bm_re    = 1'b0;
    bm_raddr = w_q;
    bm_we    = 1'b0;
    bm_waddr = node_q[NX-1:WL];
    bm_wdata = bm_rdata;
    am_re    = 1'b0;
    am_raddr = fsh[TOP_ORDER-1:0];
    am_we    = 1'b0;
    am_waddr = s_q;
    am_wdata = {1'b1, tgt_q};
    unique case (state_q)
      ST_CLEAR: begin
        am_we    = 1'b1;
        am_waddr = clr_q[TOP_ORDER-1:0];
        am_wdata = '0;
        bm_we    = (32'(clr_q) < NWORDS);
        bm_waddr = clr_q[BAW-1:0];
        bm_wdata = (clr_q == '0) ? W'(1) : '0;
      end
      ST_S_RD:   bm_re = 1'b1;
      ST_S_CHK: begin
        bm_we    = any_hit;
        bm_waddr = w_q;
        bm_wdata = bm_rdata & ~(W'(1) << pe);
      end
      ST_SPLIT: begin
        bm_re    = (i_q > tgt_q);
        bm_raddr = split_node[NX-1:WL];
        am_we    = !(i_q > tgt_q);
      end
      ST_SPL_WR, ST_SET_WR: begin
        bm_we    = 1'b1;
        bm_wdata = bm_rdata | (W'(1) << node_q[WL-1:0]);
      end
      ST_F_CHK:  am_re = !bad_free;
      ST_F_RD: begin
        am_we    = am_rdata[OW];
        am_wdata = {1'b0, am_rdata[OW-1:0]};
      end
      ST_M_RD: begin
        bm_re    = (o_q != OW'(TOP_ORDER));
        bm_raddr = buddy_node[NX-1:WL];
      end
      ST_M_CHK: begin
        bm_we    = bm_rdata[node_q[WL-1:0]];
        bm_wdata = bm_rdata & ~(W'(1) << node_q[WL-1:0]);
      end
      ST_SET_RD: begin
        bm_re    = 1'b1;
        bm_raddr = set_node[NX-1:WL];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= LG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Main sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      mval_q  <= 1'b0;
    end else begin
      // drop the taken beat unless a new result is loaded below
      if (mval_q && m_axis_tready && (state_q != ST_DONE)) mval_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + UW'(1);
          if (clr_q == UW'(UNITS - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            size_q  <= s_axis_tdata[31:0];
            offs_q  <= s_axis_tdata[63:32];
            state_q <= (s_axis_tuser == OP_FREE) ? ST_F_CHK : ST_A_CHK;
          end
        end
        ST_A_CHK: begin
          units_q <= ufull[UW-1:0];
          if (bad_size) begin
            st_q    <= STAT_BADSIZE;
            roff_q  <= '0;
            rord_q  <= '0;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_A_TGT;
          end
        end
        ST_A_TGT: begin
          tgt_q   <= tgt_c;
          o_q     <= tgt_c;
          w_q     <= BAW'(node_of(tgt_c, '0) >> WL);
          state_q <= ST_S_RD;
        end
        ST_S_RD: state_q <= ST_S_CHK;
        ST_S_CHK: begin
          if (any_hit) begin
            // take the lowest free block, then split down
            s_q     <= s_found;
            i_q     <= o_q;
            state_q <= ST_SPLIT;
          end else if (w_q != BAW'(hi_c >> WL)) begin
            w_q     <= w_q + BAW'(1);
            state_q <= ST_S_RD;
          end else if (o_q == OW'(TOP_ORDER)) begin
            st_q    <= STAT_NOMEM;
            roff_q  <= '0;
            rord_q  <= '0;
            state_q <= ST_DONE;
          end else begin
            o_q     <= o_q + OW'(1);
            w_q     <= BAW'(node_of(o_q + OW'(1), '0) >> WL);
            state_q <= ST_S_RD;
          end
        end
        ST_SPLIT: begin
          if (i_q > tgt_q) begin
            node_q  <= split_node;
            state_q <= ST_SPL_WR;
          end else begin
            st_q    <= STAT_OK;
            roff_q  <= 32'(s_q) << lg;
            rord_q  <= tgt_q;
            state_q <= ST_DONE;
          end
        end
        ST_SPL_WR: begin
          i_q     <= im1;
          state_q <= ST_SPLIT;
        end
        ST_F_CHK: begin
          s_q <= fsh[TOP_ORDER-1:0];
          if (bad_free) begin
            st_q    <= STAT_BADFREE;
            roff_q  <= '0;
            rord_q  <= '0;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_F_RD;
          end
        end
        ST_F_RD: begin
          if (!am_rdata[OW]) begin
            st_q    <= STAT_BADFREE;
            roff_q  <= '0;
            rord_q  <= '0;
            state_q <= ST_DONE;
          end else begin
            o_q     <= am_ord;
            state_q <= ST_M_RD;
          end
        end
        ST_M_RD: begin
          node_q  <= buddy_node;
          state_q <= (o_q == OW'(TOP_ORDER)) ? ST_SET_RD : ST_M_CHK;
        end
        ST_M_CHK: begin
          if (bm_rdata[node_q[WL-1:0]]) begin
            // buddy free: absorb it and climb
            s_q     <= s_q & ~(TOP_ORDER'(1) << o_q);
            o_q     <= o_q + OW'(1);
            state_q <= ST_M_RD;
          end else begin
            state_q <= ST_SET_RD;
          end
        end
        ST_SET_RD: begin
          node_q  <= set_node;
          state_q <= ST_SET_WR;
        end
        ST_SET_WR: begin
          st_q    <= STAT_OK;
          roff_q  <= '0;
          rord_q  <= o_q;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!mval_q || m_axis_tready) begin
            mval_q  <= 1'b1;
            mst_q   <= st_q;
            moff_q  <= roff_q;
            mord_q  <= rord_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mval_q;
  assign m_axis_tuser  = mst_q;
  assign m_axis_tdata  = {4'b0, mord_q, moff_q};

  `BBA_ASSERT(a_err_payload_zero, (m_axis_tvalid && (m_axis_tuser != STAT_OK)) |-> (m_axis_tdata == '0))
  `BBA_ASSERT(a_order_in_range, m_axis_tvalid |-> (m_axis_tdata[35:32] <= OW'(TOP_ORDER)))
  `BBA_ASSERT(a_bitmap_no_overlap, bm_we |-> !bm_re)

endmodule

`default_nettype wire

// File: sv/bba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic                                         re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
